// ===== src/vls_pkg.sv =====
// Shared types, constants and register indexes for the video line sequencer.
package vls_pkg;

  localparam int unsigned FrameBytesDef = 16384;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned LineW   = 10;
  localparam int unsigned OutAddrW = 14;
  localparam int unsigned LenW    = 7;
  localparam int unsigned SyncW   = 11;
  localparam int unsigned VoffW   = 8;

  localparam logic [LineW:0]   FirstActive = 11'd30;
  localparam logic [LineW-1:0] VsyncFirst  = 10'd2;
  localparam logic [LineW-1:0] VsyncLast   = 10'd4;
  localparam logic [LineW-1:0] LineFirst   = 10'd1;

  localparam logic [LenW-1:0]  BytesPerLineRst   = 7'd28;
  localparam logic             HalfModeRst       = 1'b0;
  localparam logic [LineW-1:0] ActiveLinesRst    = 10'd216;
  localparam logic [VoffW-1:0] VerticalOffsetRst = 8'd0;
  localparam logic [LineW-1:0] TotalLinesRst     = 10'd262;
  localparam logic [SyncW-1:0] HsyncWidthRst     = 11'd112;
  localparam logic [SyncW-1:0] VsyncWidthRst     = 11'd1412;

  typedef enum logic [CfgIdxW-1:0] {
    RegBytesPerLine   = 3'd0,
    RegHalfMode       = 3'd1,
    RegActiveLines    = 3'd2,
    RegVerticalOffset = 3'd3,
    RegTotalLines     = 3'd4,
    RegHsyncWidth     = 3'd5,
    RegVsyncWidth     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LenW-1:0]  bytes_per_line;
    logic             half_mode;
    logic [LineW-1:0] active_lines;
    logic [VoffW-1:0] vertical_offset;
    logic [LineW-1:0] total_lines;
    logic [SyncW-1:0] hsync_width;
    logic [SyncW-1:0] vsync_width;
  } cfg_t;

  typedef struct packed {
    logic [LineW-1:0]    line_number;
    logic                send_line;
    logic [OutAddrW-1:0] line_address;
    logic [LenW-1:0]     line_length;
    logic [SyncW-1:0]    sync_width;
    logic                frame_end;
  } result_t;

endpackage

// ===== src/vls_line_calc.sv =====
// Per-line decode: active window, sync width, next line count and read offset.
module vls_line_calc #(
  parameter int unsigned FRAME_BYTES = vls_pkg::FrameBytesDef,
  parameter int unsigned AddrW       = $clog2(FRAME_BYTES)
) (
  input  vls_pkg::cfg_t                 cfg_i,
  input  logic [vls_pkg::LineW-1:0]     line_i,
  input  logic [AddrW-1:0]              addr_i,
  output vls_pkg::result_t              result_o,
  output logic [vls_pkg::LineW-1:0]     line_next_o,
  output logic [AddrW-1:0]              addr_next_o
);

  localparam int unsigned LW   = vls_pkg::LineW;
  localparam int unsigned ExtW = (AddrW > vls_pkg::OutAddrW) ? AddrW : vls_pkg::OutAddrW;
  localparam logic [AddrW:0] FrameLim = (AddrW + 1)'(FRAME_BYTES);

  logic [LW:0]     cur_ext;
  logic [LW:0]     cur_inc;
  logic [LW:0]     win_start;
  logic [LW:0]     win_end;
  logic            active;
  logic            vsync;
  logic            advance;
  logic            wrapped;
  logic [AddrW:0]  addr_sum;
  logic [AddrW-1:0] addr_step;
  logic [ExtW-1:0] addr_ext;

  assign cur_ext   = {1'b0, line_i};
  assign cur_inc   = cur_ext + (LW + 1)'(1);
  assign win_start = vls_pkg::FirstActive + (LW + 1)'(cfg_i.vertical_offset);
  assign win_end   = win_start + {1'b0, cfg_i.active_lines};
  assign active    = (cur_ext >= win_start) && (cur_inc <= win_end);
  assign vsync     = (line_i >= vls_pkg::VsyncFirst) && (line_i <= vls_pkg::VsyncLast);
  // FirstActive is even, so with an even vertical offset the odd-offset test reduces to bit 0
  assign advance   = active && (!cfg_i.half_mode || line_i[0]);
  assign wrapped   = cur_inc > {1'b0, cfg_i.total_lines};

  assign addr_sum  = {1'b0, addr_i} + (AddrW + 1)'(cfg_i.bytes_per_line);
  assign addr_step = (addr_sum >= FrameLim) ? AddrW'(addr_sum - FrameLim) : addr_sum[AddrW-1:0];
  assign addr_ext  = ExtW'(addr_i);

  always_comb begin
    result_o.line_number  = line_i;
    result_o.send_line    = active;
    result_o.line_address = active ? addr_ext[vls_pkg::OutAddrW-1:0] : '0;
    result_o.line_length  = active ? cfg_i.bytes_per_line : '0;
    result_o.sync_width   = vsync ? cfg_i.vsync_width : cfg_i.hsync_width;
    result_o.frame_end    = wrapped;
  end

  always_comb begin
    if (wrapped) begin
      line_next_o = vls_pkg::LineFirst;
      addr_next_o = '0;
    end else begin
      line_next_o = cur_inc[LW-1:0];
      addr_next_o = advance ? addr_step : addr_i;
    end
  end

endmodule

// ===== src/video_line_sequencer.sv =====
// Top level of the video line sequencer: config registers, line state, result register.
// Latency: a result is valid the cycle after its line event transaction is accepted.
// Throughput: one transaction per cycle while the result is not stalled; the single result register is the only stage.
// in_ready_o stays high while the result register is empty or being drained.
// Reset clears the line counter to 1, the read offset to 0, config to defaults,
// and leaves no result pending.
module video_line_sequencer #(
  parameter int unsigned FRAME_BYTES = vls_pkg::FrameBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            line_event_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vls_pkg::LineW-1:0]       line_number_o,
  output logic                            send_line_o,
  output logic [vls_pkg::OutAddrW-1:0]    line_address_o,
  output logic [vls_pkg::LenW-1:0]        line_length_o,
  output logic [vls_pkg::SyncW-1:0]       sync_width_o,
  output logic                            frame_end_o,
  input  logic                            cfg_we_i,
  input  logic [vls_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vls_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned AddrW = $clog2(FRAME_BYTES);

  vls_pkg::cfg_t                cfg_q, cfg_d;
  logic [vls_pkg::LineW-1:0]    line_q, line_d;
  logic [AddrW-1:0]             addr_q, addr_d;
  vls_pkg::result_t             res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic                         in_fire;
  logic                         event_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign event_fire = in_fire && line_event_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (vls_pkg::cfg_reg_e'(cfg_index_i))
        vls_pkg::RegBytesPerLine:   cfg_d.bytes_per_line  = cfg_data_i[vls_pkg::LenW-1:0];
        vls_pkg::RegHalfMode:       cfg_d.half_mode       = cfg_data_i[0];
        vls_pkg::RegActiveLines:    cfg_d.active_lines    = cfg_data_i[vls_pkg::LineW-1:0];
        vls_pkg::RegVerticalOffset: cfg_d.vertical_offset = cfg_data_i[vls_pkg::VoffW-1:0];
        vls_pkg::RegTotalLines:     cfg_d.total_lines     = cfg_data_i[vls_pkg::LineW-1:0];
        vls_pkg::RegHsyncWidth:     cfg_d.hsync_width     = cfg_data_i[vls_pkg::SyncW-1:0];
        vls_pkg::RegVsyncWidth:     cfg_d.vsync_width     = cfg_data_i[vls_pkg::SyncW-1:0];
        default: ;
      endcase
    end
  end

  vls_pkg::result_t          calc_res;
  logic [vls_pkg::LineW-1:0] calc_line;
  logic [AddrW-1:0]          calc_addr;

  vls_line_calc #(
    .FRAME_BYTES(FRAME_BYTES),
    .AddrW      (AddrW)
  ) u_calc (
    .cfg_i      (cfg_q),
    .line_i     (line_q),
    .addr_i     (addr_q),
    .result_o   (calc_res),
    .line_next_o(calc_line),
    .addr_next_o(calc_addr)
  );

  always_comb begin
    line_d      = event_fire ? calc_line : line_q;
    addr_d      = event_fire ? calc_addr : addr_q;
    res_d       = event_fire ? calc_res : res_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      out_valid_d = event_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_line  <= vls_pkg::BytesPerLineRst;
      cfg_q.half_mode       <= vls_pkg::HalfModeRst;
      cfg_q.active_lines    <= vls_pkg::ActiveLinesRst;
      cfg_q.vertical_offset <= vls_pkg::VerticalOffsetRst;
      cfg_q.total_lines     <= vls_pkg::TotalLinesRst;
      cfg_q.hsync_width     <= vls_pkg::HsyncWidthRst;
      cfg_q.vsync_width     <= vls_pkg::VsyncWidthRst;
      line_q                <= vls_pkg::LineFirst;
      addr_q                <= '0;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      line_q      <= line_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign line_number_o  = res_q.line_number;
  assign send_line_o    = res_q.send_line;
  assign line_address_o = res_q.line_address;
  assign line_length_o  = res_q.line_length;
  assign sync_width_o   = res_q.sync_width;
  assign frame_end_o    = res_q.frame_end;

endmodule

// ===== src/vls_checker.sv =====
// Port-level assertions for the video line sequencer, bound to the top level.
module vls_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            line_event_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [vls_pkg::LineW-1:0]       line_number_o,
  input logic                            send_line_o,
  input logic [vls_pkg::OutAddrW-1:0]    line_address_o,
  input logic [vls_pkg::LenW-1:0]        line_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_event_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && line_event_i |=> out_valid_o)
    else $error("line event produced no result");

  a_idle_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_line_o |-> (line_length_o == '0) && (line_address_o == '0))
    else $error("inactive line carries address or length");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != '0)
    else $error("line number zero reported");

endmodule

bind video_line_sequencer vls_checker u_vls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .line_event_i  (line_event_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .line_number_o (line_number_o),
  .send_line_o   (send_line_o),
  .line_address_o(line_address_o),
  .line_length_o (line_length_o)
);
